[rtl/hcc_pkg.sv]
`timescale 1ns / 1ps

package hcc_pkg;

  localparam int unsigned TargetW = 64;

  localparam logic [7:0] ChEq    = 8'h3D;  // '='
  localparam logic [7:0] ChLt    = 8'h3C;  // '<'
  localparam logic [7:0] ChGt    = 8'h3E;  // '>'
  localparam logic [7:0] ChSpace = 8'h20;  // ' '
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'

  typedef enum logic [2:0] {
    PH_EXPECT_OP  = 3'd0,
    PH_AFTER_GT   = 3'd1,
    PH_AFTER_LT   = 3'd2,
    PH_AFTER_EQ   = 3'd3,
    PH_EXPECT_NUM = 3'd4,
    PH_DIGITS     = 3'd5,
    PH_FINISHED   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    CMP_EQ = 3'd0,
    CMP_GT = 3'd1,
    CMP_GE = 3'd2,
    CMP_LT = 3'd3,
    CMP_LE = 3'd4
  } cmp_e;

  typedef struct packed {
    phase_e               phase;
    cmp_e                 kind;
    logic [TargetW-1:0]   target;
    logic                 err;
  } parse_state_t;

  localparam parse_state_t ParseReset = '{
    phase:  PH_EXPECT_OP,
    kind:   CMP_EQ,
    target: '0,
    err:    1'b0
  };

endpackage

[rtl/hcc_if.sv]
`timescale 1ns / 1ps

// character request channel
interface hcc_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_code;
  logic        last_char;
  logic [31:0] hit_count;

  modport source (output valid, char_code, last_char, hit_count, input ready);
  modport sink   (input valid, char_code, last_char, hit_count, output ready);
endinterface

// result channel
interface hcc_rsp_if;
  logic valid;
  logic ready;
  logic condition_met;
  logic malformed;

  modport source (output valid, condition_met, malformed, input ready);
  modport sink   (input valid, condition_met, malformed, output ready);
endinterface

[rtl/hcc_parser.sv]
`timescale 1ns / 1ps

module hcc_parser (
  input  hcc_pkg::parse_state_t state_i,
  input  logic [7:0]            char_i,
  output hcc_pkg::parse_state_t state_o
);
  import hcc_pkg::*;

  logic               is_digit;
  logic               is_space;
  logic [3:0]         digit_val;
  logic [TargetW-1:0] target_x10;
  logic               ok;
  parse_state_t       nxt;

  assign is_digit   = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_space   = (char_i == ChSpace);
  assign digit_val  = 4'(char_i - ChZero);
  // times ten by shift-add
  assign target_x10 = (state_i.target << 3) + (state_i.target << 1);

  always_comb begin
    nxt = state_i;
    ok  = 1'b0;
    unique case (state_i.phase)
      PH_EXPECT_OP: begin
        if (is_space) begin
          ok = 1'b1;
        end else if (char_i == ChEq) begin
          ok = 1'b1;
          nxt.phase = PH_AFTER_EQ;
        end else if (char_i == ChLt) begin
          ok = 1'b1;
          nxt.phase = PH_AFTER_LT;
        end else if (char_i == ChGt) begin
          ok = 1'b1;
          nxt.phase = PH_AFTER_GT;
        end
      end
      PH_AFTER_EQ: begin
        if (char_i == ChEq) begin
          ok = 1'b1;
          nxt.kind  = CMP_EQ;
          nxt.phase = PH_EXPECT_NUM;
        end
      end
      PH_AFTER_GT, PH_AFTER_LT: begin
        if (char_i == ChEq) begin
          ok = 1'b1;
          nxt.kind  = (state_i.phase == PH_AFTER_GT) ? CMP_GE : CMP_LE;
          nxt.phase = PH_EXPECT_NUM;
        end else if (is_digit) begin
          ok = 1'b1;
          nxt.kind   = (state_i.phase == PH_AFTER_GT) ? CMP_GT : CMP_LT;
          nxt.target = TargetW'(digit_val);
          nxt.phase  = PH_DIGITS;
        end else if (is_space) begin
          ok = 1'b1;
          nxt.kind  = (state_i.phase == PH_AFTER_GT) ? CMP_GT : CMP_LT;
          nxt.phase = PH_EXPECT_NUM;
        end
      end
      PH_EXPECT_NUM: begin
        if (is_space) begin
          ok = 1'b1;
        end else if (is_digit) begin
          ok = 1'b1;
          nxt.target = TargetW'(digit_val);
          nxt.phase  = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          ok = 1'b1;
          nxt.target = target_x10 + TargetW'(digit_val);
        end else if (is_space) begin
          ok = 1'b1;
          nxt.phase = PH_FINISHED;
        end
      end
      PH_FINISHED: begin
        ok = is_space;
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    // once malformed, later characters leave the state alone
    if (state_i.err) begin
      state_o = state_i;
    end else if (!ok) begin
      state_o     = state_i;
      state_o.err = 1'b1;
    end else begin
      state_o = nxt;
    end
  end

endmodule

[rtl/hit_count_condition_check_core.sv]
`timescale 1ns / 1ps
// a result is registered once its last character leaves the input register
// (the parse step runs while the character sits in the input register)
// throughput: one character per cycle unless stalled, set by the single parse
// step per character; a waiting result does not block input: the next text
// streams in until the next last character finds the result register still full
// reset: rst_ni low clears parse state and all valid flags asynchronously
module hit_count_condition_check_core #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  hcc_req_if.sink   req_i,
  hcc_rsp_if.source rsp_o
);
  import hcc_pkg::*;

  // hit count bits that can matter: the port carries 32
  localparam int unsigned CntW = (COUNT_BITS < 32) ? COUNT_BITS : 32;

  // input register
  logic            s1_valid_q, s1_valid_d;
  logic [7:0]      s1_char_q;
  logic            s1_last_q;
  logic [CntW-1:0] s1_count_q;

  // parse state
  parse_state_t state_q, state_d;
  parse_state_t state_step;

  // result register
  logic out_valid_q, out_valid_d;
  logic out_met_q, out_met_d;
  logic out_bad_q, out_bad_d;

  logic               advance;
  logic               req_take;
  logic [TargetW-1:0] count_ext;
  logic               cmp_hit;

  // the input register drains unless it holds a last character and the
  // result register is full and stalled
  assign advance  = s1_valid_q && (!s1_last_q || !out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign req_take = req_i.valid && req_i.ready;

  hcc_parser u_parser (
    .state_i (state_q),
    .char_i  (s1_char_q),
    .state_o (state_step)
  );

  assign count_ext = TargetW'(s1_count_q);

  // compare against the target as it stands after this character
  always_comb begin
    unique case (state_step.kind)
      CMP_GT:  cmp_hit = count_ext >  state_step.target;
      CMP_GE:  cmp_hit = count_ext >= state_step.target;
      CMP_LT:  cmp_hit = count_ext <  state_step.target;
      CMP_LE:  cmp_hit = count_ext <= state_step.target;
      default: cmp_hit = count_ext == state_step.target;
    endcase
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_met_d   = out_met_q;
    out_bad_d   = out_bad_q;

    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      s1_valid_d = 1'b0;
      if (s1_last_q) begin
        // end of text: publish result and start over
        out_valid_d = 1'b1;
        out_met_d   = cmp_hit && !state_step.err;
        out_bad_d   = state_step.err;
        state_d     = ParseReset;
      end else begin
        state_d = state_step;
      end
    end
    if (req_take) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ParseReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      s1_char_q  <= req_i.char_code;
      s1_last_q  <= req_i.last_char;
      s1_count_q <= req_i.hit_count[CntW-1:0];
    end
    out_met_q <= out_met_d;
    out_bad_q <= out_bad_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.condition_met = out_met_q;
  assign rsp_o.malformed     = out_bad_q;

`ifndef SYNTHESIS
  // a malformed text never reports a met condition
  a_met_excl_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.condition_met && rsp_o.malformed))
    else $error("condition_met together with malformed");

  // parse state is back at reset after each finished text
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_last_q) |=> (state_q.phase == PH_EXPECT_OP && state_q.kind == CMP_EQ
                                && state_q.target == '0 && !state_q.err))
    else $error("parse state not cleared after last character");

  // the input register only holds when a last character meets a stalled result
  a_hold_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |-> (s1_last_q && out_valid_q && !rsp_o.ready))
    else $error("input register stalled without cause");

  // the error flag stays set until the text ends
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.err && !(advance && s1_last_q)) |=> state_q.err)
    else $error("error flag dropped mid text");
`endif

endmodule
